@@ sv/spwe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwe_pkg
// Shared constants, queue item type and back-end phase type for the
// sorted-position to WAH bitmap encoder.
// ----------------------------------------------------------------------------
package spwe_pkg;

	localparam int POS_BITS    = 40;
	localparam int GROUP_BITS  = 63;
	localparam int CNT_BITS    = 62;
	localparam int WORD_BITS   = 64;
	// group index of a position: p / 63 < 2^(POS_BITS-5)
	localparam int GRP_BITS    = POS_BITS - 5;
	// fold steps of the divide-by-63 pipe, each removes about six bits
	localparam int DIV_STEPS   = (POS_BITS + 5) / 6;
	localparam int NUM_STAGES  = DIV_STEPS + 1;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [GRP_BITS-1:0]   grp;
		logic [GROUP_BITS-1:0] mask;
		logic                  fin;
	} item_t;

	typedef enum logic [1:0] {
		PH_PLACE,
		PH_FIN,
		PH_FLUSH
	} phase_t;

endpackage

@@ sv/spwe_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwe_front
// Input side: splits each position into group index and bit mask through a
// pipelined divide-by-63 (fold of base-64 digits), then pushes to the queue.
// ----------------------------------------------------------------------------
module spwe_front import spwe_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [POS_BITS-1:0] position,
	input  logic                final_item,
	input  logic                q_full,
	output logic                push,
	output item_t               push_item
);

	logic                vld_s  [NUM_STAGES];
	logic [GRP_BITS-1:0] quot_s [NUM_STAGES];
	logic [POS_BITS-1:0] rem_s  [NUM_STAGES];
	logic                fin_s  [NUM_STAGES];

	logic                advance;
	logic [POS_BITS-1:0] rem_last;
	logic                rem_hi;
	logic [5:0]          rem_fix;
	logic [5:0]          bit_idx;

	assign advance  = !vld_s[NUM_STAGES-1] || !q_full;
	assign in_ready = advance;
	assign push     = vld_s[NUM_STAGES-1] && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_STAGES; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else if (advance) begin
			vld_s[0] <= in_valid;
			for (int k = 0; k < NUM_STAGES - 1; k++) begin
				vld_s[k+1] <= vld_s[k];
			end
		end
	end

	// p = 63*q + r; with r = 64*a + b this becomes q += a, r = a + b
	always_ff @(posedge clk) begin
		if (advance) begin
			quot_s[0] <= '0;
			rem_s[0]  <= position;
			fin_s[0]  <= final_item;
			for (int k = 0; k < NUM_STAGES - 1; k++) begin
				quot_s[k+1] <= quot_s[k] + GRP_BITS'(rem_s[k][POS_BITS-1:6]);
				rem_s[k+1]  <= POS_BITS'(rem_s[k][POS_BITS-1:6]) + POS_BITS'(rem_s[k][5:0]);
				fin_s[k+1]  <= fin_s[k];
			end
		end
	end

	// remainder is at most 64 here, one correction finishes it
	assign rem_last = rem_s[NUM_STAGES-1];
	assign rem_hi   = rem_last >= POS_BITS'(GROUP_BITS);
	assign rem_fix  = rem_hi ? 6'(rem_last - POS_BITS'(GROUP_BITS)) : rem_last[5:0];
	assign bit_idx  = 6'(GROUP_BITS - 1) - rem_fix;

	always_comb begin
		push_item.grp  = quot_s[NUM_STAGES-1] + GRP_BITS'(rem_hi);
		push_item.mask = GROUP_BITS'(1) << bit_idx;
		push_item.fin  = fin_s[NUM_STAGES-1];
	end

endmodule

@@ sv/spwe_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwe_queue
// Small FIFO of classified items between the front and back ends.
// ----------------------------------------------------------------------------
module spwe_queue import spwe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	input  logic  pop,
	output logic  full,
	output logic  head_valid,
	output item_t head_item
);

	item_t                mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full       = count_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (QPTR_BITS+1)'(1);
				2'b01:   count_q <= count_q - (QPTR_BITS+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

@@ sv/spwe_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spwe_back
// Encoding side: keeps the open group and the pending one-fill, and emits
// literal and fill words into the output register, one per cycle while it is free.
// ----------------------------------------------------------------------------
module spwe_back import spwe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  item_t                head_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_BITS-1:0] code_word,
	output logic                 last_word
);

	phase_t                phase_q, phase_d;
	logic                  seen_q, seen_d;
	logic                  gap_q, gap_d;
	logic                  held_q, held_d;
	logic [GRP_BITS-1:0]   grp_q, grp_d;
	logic [GROUP_BITS-1:0] bits_q, bits_d;
	logic [CNT_BITS-1:0]   cnt_q, cnt_d;

	logic                  out_vld_q;
	logic [WORD_BITS-1:0]  word_q;
	logic                  last_q;

	logic [GRP_BITS-1:0]   g_eff;
	logic                  grp_full;
	logic                  cnt_max;
	logic                  first_gap;
	logic                  place_hit;
	logic                  close_done;
	logic                  out_free;
	logic                  go;
	logic                  emit;
	logic                  pop_item;
	logic                  last_bit;
	logic [WORD_BITS-1:0]  word;
	logic [WORD_BITS-1:0]  held_word;
	logic [WORD_BITS-1:0]  lit_word;
	logic                  cls_emit;
	logic [WORD_BITS-1:0]  cls_word;

	assign g_eff      = seen_q ? grp_q : head_item.grp;
	assign grp_full   = &bits_q;
	assign cnt_max    = &cnt_q;
	assign first_gap  = !seen_q && (head_item.grp != '0);
	assign place_hit  = !first_gap && (head_item.grp <= g_eff);
	// a non-full group with a pending fill needs the fill out first
	assign close_done = grp_full || !held_q;
	assign out_free   = !out_vld_q || out_ready;

	assign held_word  = {2'b11, cnt_q};
	assign lit_word   = {1'b0, bits_q};
	assign cls_emit   = held_q ? (!grp_full || cnt_max) : !grp_full;
	assign cls_word   = held_q ? held_word : lit_word;

	assign go  = head_valid && (!emit || out_free);
	assign pop = go && pop_item;

	// next phase
	always_comb begin
		phase_d = phase_q;
		if (go) begin
			case (phase_q)
				PH_PLACE: begin
					if (place_hit && head_item.fin) begin
						phase_d = PH_FIN;
					end
				end
				PH_FIN: begin
					if (close_done) begin
						phase_d = grp_full ? PH_FLUSH : PH_PLACE;
					end
				end
				PH_FLUSH: phase_d = PH_PLACE;
				default:  phase_d = PH_PLACE;
			endcase
		end
	end

	// word selection and state updates
	always_comb begin
		emit     = 1'b0;
		word     = '0;
		last_bit = 1'b0;
		pop_item = 1'b0;
		seen_d   = seen_q;
		gap_d    = gap_q;
		held_d   = held_q;
		grp_d    = grp_q;
		bits_d   = bits_q;
		cnt_d    = cnt_q;
		case (phase_q)
			PH_PLACE: begin
				if (first_gap) begin
					// empty groups ahead of the first position
					emit   = 1'b1;
					word   = {2'b10, CNT_BITS'(head_item.grp)};
					seen_d = 1'b1;
					grp_d  = head_item.grp;
				end else if (place_hit) begin
					seen_d = 1'b1;
					gap_d  = 1'b0;
					grp_d  = g_eff;
					if (head_item.grp == g_eff) begin
						bits_d = bits_q | head_item.mask;
					end
					pop_item = !head_item.fin;
				end else if (gap_q) begin
					emit = 1'b1;
					if (held_q) begin
						word   = held_word;
						held_d = 1'b0;
						cnt_d  = '0;
					end else begin
						word  = {2'b10, CNT_BITS'(head_item.grp - grp_q)};
						grp_d = head_item.grp;
						gap_d = 1'b0;
					end
				end else begin
					emit = cls_emit;
					word = cls_word;
					if (grp_full) begin
						held_d = 1'b1;
						cnt_d  = (held_q && !cnt_max) ? cnt_q + CNT_BITS'(1) : CNT_BITS'(1);
					end else if (held_q) begin
						held_d = 1'b0;
						cnt_d  = '0;
					end
					if (close_done) begin
						grp_d  = grp_q + GRP_BITS'(1);
						bits_d = '0;
						gap_d  = 1'b1;
					end
				end
			end
			PH_FIN: begin
				emit     = cls_emit;
				word     = cls_word;
				last_bit = close_done && !grp_full;
				if (grp_full) begin
					held_d = 1'b1;
					cnt_d  = (held_q && !cnt_max) ? cnt_q + CNT_BITS'(1) : CNT_BITS'(1);
					bits_d = '0;
				end else if (held_q) begin
					held_d = 1'b0;
					cnt_d  = '0;
				end else begin
					pop_item = 1'b1;
					seen_d   = 1'b0;
					gap_d    = 1'b0;
					grp_d    = '0;
					bits_d   = '0;
				end
			end
			PH_FLUSH: begin
				emit     = 1'b1;
				word     = held_word;
				last_bit = 1'b1;
				pop_item = 1'b1;
				seen_d   = 1'b0;
				gap_d    = 1'b0;
				held_d   = 1'b0;
				cnt_d    = '0;
				grp_d    = '0;
				bits_d   = '0;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PLACE;
			seen_q  <= 1'b0;
			gap_q   <= 1'b0;
			held_q  <= 1'b0;
			grp_q   <= '0;
			bits_q  <= '0;
			cnt_q   <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			seen_q  <= seen_d;
			gap_q   <= gap_d;
			held_q  <= held_d;
			grp_q   <= grp_d;
			bits_q  <= bits_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (go && emit) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			word_q <= word;
			last_q <= last_bit;
		end
	end

	assign out_valid = out_vld_q;
	assign code_word = word_q;
	assign last_word = last_q;

`ifndef SYNTH
	a_held_count: assert property (@(posedge clk) disable iff (!arst_n)
		held_q |-> cnt_q != '0)
		else $error("pending one-fill with zero count");

	a_flush_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_FLUSH |-> held_q)
		else $error("flush phase without pending fill");

	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_q |-> (!held_q && !gap_q && bits_q == '0))
		else $error("state not clear before first position");

	a_gap_empty: assert property (@(posedge clk) disable iff (!arst_n)
		gap_q |-> bits_q == '0)
		else $error("gap pending with bits in open group");

	a_fin_reset: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && head_item.fin) |=> (!seen_q && phase_q == PH_PLACE))
		else $error("state not cleared after final item");
`endif

endmodule

@@ sv/sorted_positions_to_wah_encoder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_positions_to_wah_encoder_core
// Streams ascending set-bit positions into a 64-bit word-aligned hybrid
// bitmap: literals, zero-fills and merged one-fills.
// ----------------------------------------------------------------------------
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------
//  input    | in_valid / in_ready | position[39:0], final_item
//  output   | out_valid/out_ready | code_word[63:0], last_word
//
// front: one transfer per cycle unless the 4-entry queue is full and the last
// of the 8 divide-by-63 stages is occupied. back: a position in the open group
// is ORed in; one opening a later group closes the open one and sends a zero-fill
// for skipped groups, a pending one-fill going ahead of a literal or zero-fill; a
// final item closes its group and flushes a pending one-fill. out_ready low stalls
// the back, and the front once the queue is full; arst_n clears all state at once.
// ----------------------------------------------------------------------------
module sorted_positions_to_wah_encoder_core import spwe_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [POS_BITS-1:0]  position,
	input  logic                 final_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_BITS-1:0] code_word,
	output logic                 last_word
);

	logic  q_full;
	logic  push;
	item_t push_item;
	logic  pop;
	logic  head_valid;
	item_t head_item;

	spwe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.position   (position),
		.final_item (final_item),
		.q_full     (q_full),
		.push       (push),
		.push_item  (push_item)
	);

	spwe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	spwe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.code_word  (code_word),
		.last_word  (last_word)
	);

endmodule
